@@ hdl/mcwd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mcwd_pkg
// Shared types and constants of the multi-channel heartbeat watchdog.
// ----------------------------------------------------------------------------
package mcwd_pkg;

	localparam int MAX_CHECKED = 8;
	localparam int CNT_W       = 4;
	localparam int CH_W        = 3;
	localparam int TIME_W      = 32;
	localparam int PERIOD_W    = 24;
	localparam int MULT_W      = 16;
	localparam int IVAL_W      = 16;
	localparam int FRAC_W      = 8;
	localparam int LIMIT_W     = MULT_W + PERIOD_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;

	localparam logic [MULT_W-1:0]   MULT_RST     = 16'd512;
	localparam logic [IVAL_W-1:0]   INTERVAL_RST = 16'd1000;
	localparam logic [PERIOD_W-1:0] DEF_PER_RST  = 24'd1000;
	localparam logic [CNT_W-1:0]    MON_CNT_RST  = 4'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUT_MULT = 2'd0,
		REG_CHECK_INTERVAL = 2'd1,
		REG_DEFAULT_PERIOD = 2'd2,
		REG_MONITORED_COUNT = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_HEARTBEAT  = 2'd0,
		MODE_TICK       = 2'd1,
		MODE_ACTIVATE   = 2'd2,
		MODE_DEACTIVATE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACTIVATE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		mode_t               mode;
		logic [CH_W-1:0]     channel;
		logic [PERIOD_W-1:0] beat_period;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0] timed_out_channel;
		logic            last_of_run;
	} out_item_t;

	typedef struct packed {
		logic wr_en;
		logic wr_period_en;
		logic rd_en;
	} mem_ctl_t;

endpackage
`default_nettype wire

@@ hdl/mcwd_chan_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mcwd_chan_mem
// Per-channel store of last heartbeat time and declared period, one write
// port and one registered read port each.
// ----------------------------------------------------------------------------
module mcwd_chan_mem
	import mcwd_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int IDX_W = 3
) (
	input  wire logic                clk,
	input  wire mem_ctl_t            ctl,
	input  wire logic [IDX_W-1:0]    wr_addr,
	input  wire logic [TIME_W-1:0]   wr_time,
	input  wire logic [PERIOD_W-1:0] wr_period,
	input  wire logic [IDX_W-1:0]    rd_addr,
	output logic      [TIME_W-1:0]   rd_time,
	output logic      [PERIOD_W-1:0] rd_period
);

	logic [TIME_W-1:0]   time_mem [DEPTH];
	logic [PERIOD_W-1:0] period_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			time_mem[wr_addr] <= wr_time;
		end
		if (ctl.wr_en && ctl.wr_period_en) begin
			period_mem[wr_addr] <= wr_period;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_time   <= time_mem[rd_addr];
			rd_period <= period_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/multi_channel_heartbeat_watchdog_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_core
// Heartbeat timeout watchdog over up to eight monitored channels.
//
// A command transaction is taken when start is high and busy is low. cmd.mode
// selects heartbeat, time tick, activate or deactivate. Configuration is
// written through cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write it only while the block is idle.
//
// Heartbeat, deactivate and a tick with no scan leave busy low. Activate keeps
// busy high while it does one memory write per checked channel. A tick that
// ends a check interval while output is enabled keeps busy high through one
// memory read per checked channel, then the multiply and compare stages; its
// last result shows in the cycle in which busy falls.
//
// Timeout results come out on result with result_valid high for exactly one
// cycle, in ascending channel order, the final one marked by last_of_run. The
// receiver cannot stall them. Reset clears time, channel seen flags and the
// output enable and loads the register defaults; channel memory contents are
// undefined until written.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog_core
	import mcwd_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire in_item_t              cmd,
	output logic                       result_valid,
	output out_item_t                  result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = (CHANNELS < MAX_CHECKED) ? CHANNELS : MAX_CHECKED;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [MULT_W-1:0]   mult_q;
	logic [IVAL_W-1:0]   interval_q;
	logic [PERIOD_W-1:0] def_period_q;
	logic [CNT_W-1:0]    mon_cnt_q;

	logic [TIME_W-1:0]   time_q;
	logic [IVAL_W-1:0]   countdown_q;
	logic                out_en_q;
	logic [DEPTH-1:0]    seen_q;
	state_t              state_q;
	state_t              state_nxt;
	logic [CNT_W-1:0]    idx_q;

	logic                p1_s1;
	logic                v_s1;
	logic [CH_W-1:0]     ch_s1;
	logic                p2_s2;
	logic                v_s2;
	logic [CH_W-1:0]     ch_s2;
	logic [TIME_W-1:0]   elapsed_s2;
	logic [LIMIT_W-1:0]  limit_s2;

	logic                pend_v_q;
	logic [CH_W-1:0]     pend_ch_q;
	logic                res_v_q;
	out_item_t           res_q;

	logic [CNT_W-1:0]    chk_cnt;
	logic                accept;
	logic                hb_ok;
	logic                scan_due;
	logic                idx_live;
	logic                scan_end;
	logic                hit;
	mem_ctl_t            mem_ctl;
	logic [IDX_W-1:0]    wr_addr;
	logic [PERIOD_W-1:0] wr_period;
	logic [IDX_W-1:0]    idx_addr;
	logic [TIME_W-1:0]   rd_time;
	logic [PERIOD_W-1:0] rd_period;

	assign cfg_ready = 1'b1;
	assign chk_cnt   = (mon_cnt_q > DEPTH_C) ? DEPTH_C : mon_cnt_q;
	assign accept    = start && !busy;
	assign hb_ok     = ({1'b0, cmd.channel} < DEPTH_C);
	assign scan_due  = (countdown_q <= IVAL_W'(1)) && out_en_q;
	assign idx_live  = (idx_q < chk_cnt);
	assign idx_addr  = idx_q[IDX_W-1:0];
	assign scan_end  = (state_q == ST_SCAN) && !idx_live && !p1_s1 && !p2_s2;
	assign hit       = p2_s2 && v_s2 && ({elapsed_s2, FRAC_W'(0)} > limit_s2);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q       <= MULT_RST;
			interval_q   <= INTERVAL_RST;
			def_period_q <= DEF_PER_RST;
			mon_cnt_q    <= MON_CNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_TIMEOUT_MULT: begin
					mult_q <= cfg_data[MULT_W-1:0];
				end
				REG_CHECK_INTERVAL: begin
					interval_q <= cfg_data[IVAL_W-1:0];
				end
				REG_DEFAULT_PERIOD: begin
					def_period_q <= cfg_data[PERIOD_W-1:0];
				end
				REG_MONITORED_COUNT: begin
					mon_cnt_q <= cfg_data[CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.mode == MODE_ACTIVATE) begin
					state_nxt = ST_ACTIVATE;
				end else if (accept && cmd.mode == MODE_TICK && scan_due) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_ACTIVATE: begin
				if (!idx_live) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy         = 1'b1;
		mem_ctl      = '0;
		wr_addr      = idx_addr;
		wr_period    = def_period_q;
		case (state_q)
			ST_IDLE: begin
				busy                 = 1'b0;
				wr_addr              = cmd.channel[IDX_W-1:0];
				wr_period            = cmd.beat_period;
				mem_ctl.wr_en        = accept && cmd.mode == MODE_HEARTBEAT && hb_ok;
				mem_ctl.wr_period_en = (cmd.beat_period != '0);
			end
			ST_ACTIVATE: begin
				mem_ctl.wr_en        = idx_live;
				mem_ctl.wr_period_en = 1'b1;
			end
			ST_SCAN: begin
				mem_ctl.rd_en = idx_live;
			end
			default: begin
			end
		endcase
	end

	mcwd_chan_mem #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W)
	) u_mem (
		.clk      (clk),
		.ctl      (mem_ctl),
		.wr_addr  (wr_addr),
		.wr_time  (time_q),
		.wr_period(wr_period),
		.rd_addr  (idx_addr),
		.rd_time  (rd_time),
		.rd_period(rd_period)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			time_q      <= '0;
			countdown_q <= INTERVAL_RST;
			out_en_q    <= 1'b0;
			seen_q      <= '0;
			p1_s1       <= 1'b0;
			v_s1        <= 1'b0;
			p2_s2       <= 1'b0;
			v_s2        <= 1'b0;
			pend_v_q    <= 1'b0;
			res_v_q     <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						case (cmd.mode)
							MODE_HEARTBEAT: begin
								if (hb_ok) begin
									seen_q[cmd.channel[IDX_W-1:0]] <= 1'b1;
								end
							end
							MODE_TICK: begin
								time_q <= time_q + TIME_W'(1);
								if (countdown_q <= IVAL_W'(1)) begin
									countdown_q <= interval_q;
								end else begin
									countdown_q <= countdown_q - IVAL_W'(1);
								end
							end
							MODE_ACTIVATE: begin
								out_en_q <= 1'b1;
							end
							MODE_DEACTIVATE: begin
								out_en_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ACTIVATE: begin
					if (idx_live) begin
						seen_q[idx_addr] <= 1'b1;
						idx_q            <= idx_q + CNT_W'(1);
					end
				end
				ST_SCAN: begin
					if (idx_live) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase

			p1_s1 <= mem_ctl.rd_en;
			v_s1  <= mem_ctl.rd_en && seen_q[idx_addr];
			p2_s2 <= p1_s1;
			v_s2  <= v_s1;

			// hold one hit back so the final one can be marked
			res_v_q <= pend_v_q && (hit || scan_end);
			if (hit) begin
				pend_v_q <= 1'b1;
			end else if (scan_end) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		ch_s1      <= idx_q[CH_W-1:0];
		ch_s2      <= ch_s1;
		elapsed_s2 <= time_q - rd_time;
		limit_s2   <= LIMIT_W'(mult_q) * LIMIT_W'(rd_period);
		if (hit) begin
			pend_ch_q <= ch_s2;
		end
		res_q.timed_out_channel <= pend_ch_q;
		res_q.last_of_run       <= !hit;
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

endmodule
`default_nettype wire

@@ hdl/mcwd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mcwd_checker
// Port-level checks of the heartbeat watchdog, bound to the top level.
// ----------------------------------------------------------------------------
module mcwd_checker
	import mcwd_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire in_item_t              cmd,
	input wire logic                  result_valid,
	input wire out_item_t             result,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	// results only come out of a scan
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a preceding scan");

	// a result that is not the last leaves the scan still running
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last_of_run) |-> busy)
		else $error("run ended without a last result");

	// heartbeat and deactivate leave busy low and give no result
	a_short_cmds: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.mode == MODE_HEARTBEAT || cmd.mode == MODE_DEACTIVATE))
		|=> (!busy && !result_valid))
		else $error("heartbeat or deactivate transaction did not finish in one cycle");

	// a tick never yields a result in the next cycle
	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.mode == MODE_TICK) |=> !result_valid)
		else $error("result too soon after tick transaction");

endmodule

bind multi_channel_heartbeat_watchdog_core mcwd_checker u_mcwd_checker (.*);
`default_nettype wire
